// File: hw/rtl/dtq_pkg.sv
// Shared constants, codes and controller/datapath types of the delta timer queue.
package dtq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int SLOT_W     = $clog2(NUM_TIMERS);
  localparam int LINK_W     = $clog2(NUM_TIMERS + 1);
  localparam int SLOT_CMP_W = 7;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [SLOT_W-1:0] slot_ix_t;

  // The sentinel link value marks the end of the queue.
  localparam link_t NIL = LINK_W'(NUM_TIMERS);

  typedef enum logic [0:0] {
    OP_UPDATE = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KIND_FIRED      = 3'd0,
    KIND_CMP_SET    = 3'd1,
    KIND_CMP_CLEAR  = 3'd2,
    KIND_IDLE       = 3'd3,
    KIND_INS_OK     = 3'd4,
    KIND_INS_REJECT = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_REJECT,
    DP_IDLE_RES,
    DP_INS_START,
    DP_WALK,
    DP_LINK,
    DP_INS_OK,
    DP_UPD_CLEAR,
    DP_UPD_CMP,
    DP_UPD_FIRE
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_LINK,
    S_INS_OK,
    S_UPDATE
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   use_cur;
  } dtq_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_insert;
    logic slot_bad;
    logic head_nil;
    logic walk_stop;
    logic head_live;
    logic periodic;
  } dtq_status_t;

endpackage

// File: hw/rtl/dtq_if.sv
// Handshake channel interfaces for timer commands and their results.
interface dtq_req_if;
  logic        valid;
  logic        ready;
  logic [0:0]  op;
  logic [31:0] now_count;
  logic [3:0]  slot;
  logic [63:0] delay;
  logic [63:0] reload;
  logic [0:0]  notify;
  logic signed [31:0] message;

  modport source (output valid, op, now_count, slot, delay, reload, notify, message,
                  input ready);
  modport sink (input valid, op, now_count, slot, delay, reload, notify, message,
                output ready);
endinterface

interface dtq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  fired_slot;
  logic signed [31:0] fired_message;
  logic [31:0] compare_value;
  logic [0:0]  last;

  modport source (output valid, kind, fired_slot, fired_message, compare_value, last,
                  input ready);
  modport sink (input valid, kind, fired_slot, fired_message, compare_value, last,
                output ready);
endinterface

// File: hw/rtl/dtq_ctrl.sv
// Sequencing state machine of the delta timer queue.
module dtq_ctrl
  import dtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  dtq_status_t status,
  output dtq_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.op      = DP_NOP;
    cmd.use_cur = 1'b0;
    req_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.out_free) begin
          if (status.is_insert) begin
            if (status.slot_bad) begin
              cmd.op     = DP_REJECT;
              state_next = S_IDLE;
            end else begin
              cmd.op     = DP_INS_START;
              state_next = S_WALK;
            end
          end else if (status.head_nil) begin
            cmd.op     = DP_IDLE_RES;
            state_next = S_IDLE;
          end else begin
            state_next = S_UPDATE;
          end
        end
      end
      S_WALK: begin
        cmd.use_cur = 1'b1;
        if (status.walk_stop) begin
          state_next = S_LINK;
        end else begin
          cmd.op = DP_WALK;
        end
      end
      S_LINK: begin
        cmd.use_cur = 1'b1;
        cmd.op      = DP_LINK;
        state_next  = status.is_insert ? S_INS_OK : S_UPDATE;
      end
      S_INS_OK: begin
        if (status.out_free) begin
          cmd.op     = DP_INS_OK;
          state_next = S_IDLE;
        end
      end
      S_UPDATE: begin
        if (status.out_free) begin
          if (status.head_nil) begin
            cmd.op     = DP_UPD_CLEAR;
            state_next = S_IDLE;
          end else if (status.head_live) begin
            cmd.op     = DP_UPD_CMP;
            state_next = S_IDLE;
          end else begin
            // The head expires; a periodic slot goes back in through a walk.
            cmd.op     = DP_UPD_FIRE;
            state_next = status.periodic ? S_WALK : S_UPDATE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/dtq_datapath.sv
// Slot storage, linked queue, walk registers and result register.
module dtq_datapath
  import dtq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dtq_cmd_t           cmd,
  output dtq_status_t        status,
  input  logic [0:0]         in_op,
  input  logic [31:0]        in_now_count,
  input  logic [3:0]         in_slot,
  input  logic [63:0]        in_delay,
  input  logic [63:0]        in_reload,
  input  logic [0:0]         in_notify,
  input  logic signed [31:0] in_message,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic [3:0]         out_fired_slot,
  output logic signed [31:0] out_fired_message,
  output logic [31:0]        out_compare_value,
  output logic [0:0]         out_last
);

  logic [63:0] remaining    [NUM_TIMERS];
  logic [63:0] period       [NUM_TIMERS];
  logic [31:0] slot_message [NUM_TIMERS];
  logic        slot_notify  [NUM_TIMERS];
  link_t       next_link    [NUM_TIMERS];
  link_t       prev_link    [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] queued;
  link_t       head;
  link_t       tail;
  logic [31:0] last_count;

  op_t         op_r;
  logic [31:0] now_r;
  logic [3:0]  slot_r;
  logic [63:0] delay_r;
  logic [63:0] reload_r;
  logic        notify_r;
  logic [31:0] msg_r;
  logic        first;
  logic [63:0] d;
  link_t       cur;
  slot_ix_t    tgt;

  slot_ix_t    rd_ix;
  slot_ix_t    in_ix;
  logic [63:0] rd_rem;
  logic [63:0] rd_period;
  link_t       rd_next;
  link_t       rd_prev;
  logic [31:0] elapsed;
  logic [63:0] rem_left;
  logic        cur_nil;
  link_t       prior;
  logic        out_free;

  assign rd_ix     = cmd.use_cur ? cur[SLOT_W-1:0] : head[SLOT_W-1:0];
  assign in_ix     = SLOT_W'(slot_r);
  assign rd_rem    = remaining[rd_ix];
  assign rd_period = period[rd_ix];
  assign rd_next   = next_link[rd_ix];
  assign rd_prev   = prev_link[rd_ix];
  // Only the first pass of an update sees the elapsed count.
  assign elapsed   = first ? (now_r - last_count) : 32'd0;
  assign rem_left  = rd_rem - {32'd0, elapsed};
  assign cur_nil   = (cur == NIL);
  assign prior     = cur_nil ? tail : rd_prev;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    status.out_free  = out_free;
    status.is_insert = (op_r == OP_INSERT);
    status.slot_bad  = (SLOT_CMP_W'(slot_r) >= SLOT_CMP_W'(NUM_TIMERS)) || queued[in_ix];
    status.head_nil  = (head == NIL);
    status.walk_stop = cur_nil || (d < rd_rem);
    status.head_live = (rd_rem > {32'd0, elapsed});
    status.periodic  = (rd_period != 64'd0);
  end

  // Queue control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      queued     <= '0;
      head       <= NIL;
      tail       <= NIL;
      last_count <= 32'd0;
    end else begin
      unique case (cmd.op)
        DP_LINK: begin
          queued[tgt] <= 1'b1;
          if (prior == NIL) begin
            head <= LINK_W'(tgt);
          end
          if (cur_nil) begin
            tail <= LINK_W'(tgt);
          end
        end
        DP_UPD_CLEAR: begin
          last_count <= 32'd0;
        end
        DP_UPD_CMP: begin
          last_count <= now_r;
        end
        DP_UPD_FIRE: begin
          last_count   <= now_r;
          queued[rd_ix] <= 1'b0;
          head         <= rd_next;
          if (rd_next == NIL) begin
            tail <= NIL;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Slot storage and walk registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        op_r     <= op_t'(in_op);
        now_r    <= in_now_count;
        slot_r   <= in_slot;
        delay_r  <= in_delay;
        reload_r <= in_reload;
        notify_r <= in_notify[0];
        msg_r    <= in_message;
        first    <= 1'b1;
      end
      DP_INS_START: begin
        period[in_ix]       <= reload_r;
        slot_notify[in_ix]  <= notify_r;
        slot_message[in_ix] <= msg_r;
        d   <= delay_r;
        cur <= head;
        tgt <= in_ix;
      end
      DP_WALK: begin
        d   <= d - rd_rem;
        cur <= rd_next;
      end
      DP_LINK: begin
        remaining[tgt] <= d;
        next_link[tgt] <= cur;
        prev_link[tgt] <= prior;
        if (!cur_nil) begin
          remaining[rd_ix] <= rd_rem - d;
          prev_link[rd_ix] <= LINK_W'(tgt);
        end
        if (prior != NIL) begin
          next_link[prior[SLOT_W-1:0]] <= LINK_W'(tgt);
        end
      end
      DP_UPD_CMP: begin
        remaining[rd_ix] <= rem_left;
      end
      DP_UPD_FIRE: begin
        first <= 1'b0;
        if (rd_next != NIL) begin
          prev_link[rd_next[SLOT_W-1:0]] <= NIL;
        end
        if (rd_period != 64'd0) begin
          d   <= rd_period;
          cur <= rd_next;
          tgt <= rd_ix;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: holds one item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      priority case (1'b1)
        (cmd.op == DP_REJECT) || (cmd.op == DP_IDLE_RES) || (cmd.op == DP_INS_OK) ||
        (cmd.op == DP_UPD_CLEAR) || (cmd.op == DP_UPD_CMP): out_valid <= 1'b1;
        (cmd.op == DP_UPD_FIRE): out_valid <= slot_notify[rd_ix] || (out_valid && !out_ready);
        out_ready: out_valid <= 1'b0;
        default: out_valid <= out_valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_REJECT, DP_INS_OK: begin
        out_kind          <= (cmd.op == DP_REJECT) ? KIND_INS_REJECT : KIND_INS_OK;
        out_fired_slot    <= slot_r;
        out_fired_message <= 32'sd0;
        out_compare_value <= 32'd0;
        out_last          <= 1'b1;
      end
      DP_IDLE_RES, DP_UPD_CLEAR: begin
        out_kind          <= (cmd.op == DP_IDLE_RES) ? KIND_IDLE : KIND_CMP_CLEAR;
        out_fired_slot    <= 4'd0;
        out_fired_message <= 32'sd0;
        out_compare_value <= 32'd0;
        out_last          <= 1'b1;
      end
      DP_UPD_CMP: begin
        out_kind          <= KIND_CMP_SET;
        out_fired_slot    <= 4'd0;
        out_fired_message <= 32'sd0;
        out_compare_value <= now_r + rem_left[31:0];
        out_last          <= 1'b1;
      end
      DP_UPD_FIRE: begin
        if (slot_notify[rd_ix]) begin
          out_kind          <= KIND_FIRED;
          out_fired_slot    <= 4'(rd_ix);
          out_fired_message <= slot_message[rd_ix];
          out_compare_value <= 32'd0;
          out_last          <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/delta_timer_queue_unit.sv
// Work: an insert walks past each queued slot that falls due no later than it, then links
// in; an update expires each due head slot in turn and walks each periodic one back in, and
// on an empty queue gives an idle result. Output stalls hold the work.
// Throughput: one item at a time; the next item is accepted the cycle after the last result
// of the current one is loaded into the output register. The slot walk sets the rate.
// Reset (synchronous, active high) empties the queue and clears the last count.
module delta_timer_queue_unit
  import dtq_pkg::*;
(
  input logic      clk,
  input logic      rst,
  dtq_req_if.sink  req,
  dtq_rsp_if.source rsp
);

  dtq_cmd_t    cmd;
  dtq_status_t status;

  dtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dtq_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .in_op             (req.op),
    .in_now_count      (req.now_count),
    .in_slot           (req.slot),
    .in_delay          (req.delay),
    .in_reload         (req.reload),
    .in_notify         (req.notify),
    .in_message        (req.message),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_kind          (rsp.kind),
    .out_fired_slot    (rsp.fired_slot),
    .out_fired_message (rsp.fired_message),
    .out_compare_value (rsp.compare_value),
    .out_last          (rsp.last)
  );

endmodule

// File: hw/rtl/dtq_checker.sv
// Port-level checks of the delta timer queue, bound to the top level.
module dtq_checker
  import dtq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  rsp_kind,
  input logic [31:0] rsp_compare_value,
  input logic [0:0]  rsp_last
);

  // A held result stays offered until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result item dropped before it was taken");

  // Items are worked one at a time: no accept right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item accepted while another is in work");

  // Only a fired result can be followed by more results of the same item.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp_kind == KIND_FIRED) == (rsp_last == 1'b0)))
    else $error("last flag does not match result kind");

  a_fired_no_cmp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind == KIND_FIRED) |-> (rsp_compare_value == 32'd0))
    else $error("fired result carries a compare value");

endmodule

bind delta_timer_queue_unit dtq_checker u_dtq_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_kind          (rsp.kind),
  .rsp_compare_value (rsp.compare_value),
  .rsp_last          (rsp.last)
);
